FILE: hw/rtl/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list package
// Field widths, command codes and status codes used by the list and its testbench.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam cmd_t CMD_INSERT = 3'd0;
  localparam cmd_t CMD_READ   = 3'd1;
  localparam cmd_t CMD_LOCATE = 3'd2;
  localparam cmd_t CMD_DELETE = 3'd3;
  localparam cmd_t CMD_CLEAR  = 3'd4;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_BADPOS   = 3'd2;
  localparam status_t ST_EMPTY    = 3'd3;
  localparam status_t ST_NOTFOUND = 3'd4;

endpackage

FILE: hw/rtl/pal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/positional_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list
// Bounded ordered list of signed words with 1-based positions, kept in a RAM
// and updated by a small sequencer that moves one entry at a time.
// ----------------------------------------------------------------------------
// Usage:
// A command transfer happens at a rising edge where start is high and busy is
// low; command_i, position_i and value_i are sampled then. Commands are insert,
// read, locate, delete and clear. Every command gives exactly one result,
// shown for one cycle while done_o is high; the receiver cannot stall it.
// The result carries the entry read or deleted, the position found by a
// locate, a status code and the entry count after the command.
// Timing: a command that fails a check, a clear and an unused code produce
// their result in the cycle after the transfer without raising busy. Other
// commands keep busy high while the sequencer works through the RAM, which
// has one read and one write port with a registered read, so every entry
// visited passes through a fetch state and a use state:
//   read   : the entry at the position
//   insert : entries from the end back to the position, then a put state
//   delete : entries from the position to the end
//   locate : entries from the first up to a match, or all when none matches
// done_o rises in the cycle busy falls, and a new command may be taken then.
// Reset clears the count, so the list starts empty; the RAM is not cleared
// because only positions that an insert wrote are ever read.
// ----------------------------------------------------------------------------
module positional_array_list #(
  parameter int DEPTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pal_pkg::CMD_W-1:0]     command_i,
  input  logic [pal_pkg::POS_W-1:0]     position_i,
  input  logic signed [pal_pkg::VAL_W-1:0] value_i,
  output logic                          done_o,
  output logic signed [pal_pkg::VAL_W-1:0] result_value_o,
  output logic [pal_pkg::POS_W-1:0]     found_position_o,
  output logic [pal_pkg::ST_W-1:0]      status_o,
  output logic [pal_pkg::POS_W-1:0]     entry_count_o
);

  import pal_pkg::*;

  // Index width, count width, and a compare width that holds both the count
  // and a position plus one without overflow.
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_USE   = 2'd2;
  localparam logic [1:0] S_PUT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  cmd_t              mode_q, mode_d;
  logic [AW-1:0]     k_q, k_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [AW-1:0]     tgt_q, tgt_d;
  logic              first_q, first_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic [VAL_W-1:0]  res_q, res_d;
  logic [POS_W-1:0]  found_q, found_d;
  status_t           status_q, status_d;
  logic              done_q, done_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  logic [WW-1:0]     cnt_w;
  logic [WW-1:0]     pos_w;
  logic [WW-1:0]     kp1_w;
  logic [AW-1:0]     nk;
  logic [WW-1:0]     nkp1_w;
  logic              accept;

  assign accept = start && !busy;
  assign cnt_w  = WW'(count_q);
  assign pos_w  = WW'(position_i);
  assign kp1_w  = WW'(k_q) + WW'(1);
  // Delete: the first use captures the removed entry, later uses shift one.
  assign nk     = first_q ? k_q : k_q + AW'(1);
  assign nkp1_w = WW'(nk) + WW'(1);

  pal_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    mode_d    = mode_q;
    k_d       = k_q;
    addr_d    = addr_q;
    tgt_d     = tgt_q;
    first_d   = first_q;
    val_d     = val_q;
    res_d     = res_q;
    found_d   = found_q;
    status_d  = status_q;
    done_d    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d   = command_i;
          val_d    = value_i;
          res_d    = '0;
          found_d  = '0;
          first_d  = 1'b1;
          status_d = ST_OK;
          case (command_i)
            CMD_INSERT: begin
              if (cnt_w >= WW'(DEPTH)) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else if (pos_w == '0 || pos_w > cnt_w + WW'(1)) begin
                status_d = ST_BADPOS;
                done_d   = 1'b1;
              end else begin
                tgt_d = AW'(pos_w - WW'(1));
                k_d   = AW'(count_q);
                if (cnt_w == pos_w - WW'(1)) begin
                  state_d = S_PUT;
                end else begin
                  addr_d  = AW'(cnt_w - WW'(1));
                  state_d = S_FETCH;
                end
              end
            end
            CMD_READ, CMD_DELETE: begin
              if (cnt_w == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else if (pos_w == '0 || pos_w > cnt_w) begin
                status_d = ST_BADPOS;
                done_d   = 1'b1;
              end else begin
                k_d     = AW'(pos_w - WW'(1));
                addr_d  = AW'(pos_w - WW'(1));
                state_d = S_FETCH;
              end
            end
            CMD_LOCATE: begin
              if (cnt_w == '0) begin
                status_d = ST_EMPTY;
                done_d   = 1'b1;
              end else begin
                k_d     = '0;
                addr_d  = '0;
                state_d = S_FETCH;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_FETCH: begin
        state_d = S_USE;
      end

      S_USE: begin
        case (mode_q)
          CMD_INSERT: begin
            // Move entry k-1 back to k, walking toward the insert point.
            ram_we = 1'b1;
            k_d    = k_q - AW'(1);
            if (k_q - AW'(1) == tgt_q) begin
              state_d = S_PUT;
            end else begin
              addr_d  = k_q - AW'(2);
              state_d = S_FETCH;
            end
          end
          CMD_READ: begin
            res_d   = ram_rdata;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
          CMD_LOCATE: begin
            if (ram_rdata == val_q) begin
              found_d = kp1_w[POS_W-1:0];
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (kp1_w == cnt_w) begin
              status_d = ST_NOTFOUND;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              k_d     = k_q + AW'(1);
              addr_d  = k_q + AW'(1);
              state_d = S_FETCH;
            end
          end
          CMD_DELETE: begin
            if (first_q) begin
              res_d = ram_rdata;
            end else begin
              ram_we = 1'b1;
            end
            first_d = 1'b0;
            if (nkp1_w < cnt_w) begin
              k_d     = nk;
              addr_d  = nk + AW'(1);
              state_d = S_FETCH;
            end else begin
              count_d = count_q - CW'(1);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_q;
        ram_wdata = val_q;
        count_d   = count_q + CW'(1);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      first_q <= first_d;
    end
  end

  // Datapath and result registers carry no reset.
  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    k_q      <= k_d;
    addr_q   <= addr_d;
    tgt_q    <= tgt_d;
    val_q    <= val_d;
    res_q    <= res_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign result_value_o   = res_q;
  assign found_position_o = found_q;
  assign status_o         = status_q;
  assign entry_count_o    = cnt_w[POS_W-1:0];

  // The count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // A clear finishes in the next cycle with an empty list.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_CLEAR) |=> (done_o && entry_count_o == '0))
    else $error("clear did not empty the list");

  // A command that failed its check leaves the count untouched.
  a_fail_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> $stable(count_q))
    else $error("failed command changed the count");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives insert, read, locate, delete, clear and unused commands into the
// list, predicts each result from a model of the list contents that is kept
// inside a scoreboard, and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import pal_pkg::*;

  localparam int DEPTH = 32;

  // Cycles without a command transfer or a result before the run is declared
  // hung. The slowest commands walk the whole list, such as a delete at
  // position 1 of a full list, and sender gaps add to the wait.
  localparam int WATCHDOG_LIMIT = 2000;

  // Cycles to wait after the last expected result, enough for the longest
  // command to finish if a stray result were still on its way.
  localparam int DRAIN_CYCLES = 100;

  localparam int DIRECTED_ITEMS = 25;
  localparam int PHASE_ITEMS = 475;
  localparam int MIX_RUN = 40;

  // Values that recur often so that locate meets duplicates and extremes.
  localparam logic [VAL_W-1:0] VALUE_POOL [8] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h0000_002a
  };

  // Command mixes for the random part: one leans toward a full list, one
  // toward an empty one, and one stays in between.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
  } op_mix_e;

  typedef struct packed {
    logic [VAL_W-1:0] rd_value;
    logic [POS_W-1:0] found_pos;
    status_t          status;
    logic [POS_W-1:0] count;
  } list_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the list, computes the result of
  // every accepted command, and compares the results from the block against
  // those in order.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [VAL_W-1:0] words [DEPTH];
    int               held;
    list_result_t     pending_results[$];
    int               mismatches;

    function new();
      foreach (words[k]) words[k] = '0;
      held = 0;
      mismatches = 0;
    endfunction

    // Applies one command to the list copy and returns what it yields.
    function list_result_t predict_list_op(cmd_t c, logic [POS_W-1:0] p,
                                           logic [VAL_W-1:0] v);
      list_result_t r;
      int pi;
      int k;
      r = '0;
      r.status = ST_OK;
      pi = int'(p);
      case (c)
        CMD_INSERT: begin
          // The full check wins over the position check.
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else if (pi < 1 || pi > held + 1) begin
            r.status = ST_BADPOS;
          end else begin
            for (k = held; k >= pi; k--) words[k] = words[k-1];
            words[pi-1] = v;
            held++;
          end
        end
        CMD_READ: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (pi < 1 || pi > held) begin
            r.status = ST_BADPOS;
          end else begin
            r.rd_value = words[pi-1];
          end
        end
        CMD_LOCATE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NOTFOUND;
            for (k = 0; k < held; k++) begin
              if (words[k] == v) begin
                r.found_pos = POS_W'(k + 1);
                r.status = ST_OK;
                break;
              end
            end
          end
        end
        CMD_DELETE: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else if (pi < 1 || pi > held) begin
            r.status = ST_BADPOS;
          end else begin
            r.rd_value = words[pi-1];
            for (k = pi - 1; k + 1 < held; k++) words[k] = words[k+1];
            held--;
          end
        end
        CMD_CLEAR: begin
          held = 0;
        end
        default: begin
        end
      endcase
      r.count = POS_W'(held);
      return r;
    endfunction

    function void note_command(cmd_t c, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
      pending_results.push_back(predict_list_op(c, p, v));
    endfunction

    task report_mismatch(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      // Only the first 50 are printed; all of them count.
      if (mismatches < 50) begin
        $display("%0t: MISMATCH %s: got %0h, wanted %0h", $realtime, what, got, want);
      end
      mismatches++;
    endtask

    task check_result(list_result_t got);
      list_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command waiting", VAL_W'(got.status), '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.rd_value !== want.rd_value) begin
        report_mismatch("result_value", got.rd_value, want.rd_value);
      end
      if (got.found_pos !== want.found_pos) begin
        report_mismatch("found_position", VAL_W'(got.found_pos), VAL_W'(want.found_pos));
      end
      if (got.status !== want.status) begin
        report_mismatch("status", VAL_W'(got.status), VAL_W'(want.status));
      end
      if (got.count !== want.count) begin
        report_mismatch("entry_count", VAL_W'(got.count), VAL_W'(want.count));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block.
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [CMD_W-1:0]        command_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    done_o;
  logic signed [VAL_W-1:0] result_value_o;
  logic [POS_W-1:0]        found_position_o;
  logic [ST_W-1:0]         status_o;
  logic [POS_W-1:0]        entry_count_o;

  list_scoreboard sb;
  int             sender_idle_pct;
  int             idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  positional_array_list #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .command_i       (command_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .result_value_o  (result_value_o),
    .found_position_o(found_position_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o)
  );

  // --------------------------------------------------------------------------
  // Command driver. Inputs change only at the falling edge, so the block sees
  // them settled at the rising edge. A transfer is taken at a rising edge
  // where start is high and busy is low; busy is read right at that edge,
  // before the block updates it. When the sender is to idle, start drops at
  // one falling edge and rises again at a later one, never both in one step.
  // --------------------------------------------------------------------------
  task automatic send_cmd(cmd_t c, logic [POS_W-1:0] p, logic [VAL_W-1:0] v);
    int gap;
    gap = 0;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      // Mostly short gaps, with an occasional long one.
      gap = ($urandom_range(9) == 0) ? $urandom_range(12, 4) : $urandom_range(3, 1);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= c;
    position_i <= p;
    value_i    <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(c, p, v);
  endtask

  // Picks the next random command. The list copy in the scoreboard is up to
  // date here, because each command is noted before the next one is made, so
  // positions can be aimed at the current list and locate can look for words
  // that are really stored.
  task automatic send_random_cmd(op_mix_e mix);
    int               r;
    int               hi;
    int               ins_lim;
    int               rd_lim;
    int               loc_lim;
    int               del_lim;
    int               clr_lim;
    cmd_t             c;
    logic [POS_W-1:0] p;
    logic [VAL_W-1:0] v;

    case (mix)
      MIX_FILL: begin
        ins_lim = 60; rd_lim = 70; loc_lim = 82; del_lim = 95; clr_lim = 97;
      end
      MIX_DRAIN: begin
        ins_lim = 15; rd_lim = 30; loc_lim = 45; del_lim = 93; clr_lim = 95;
      end
      default: begin
        ins_lim = 35; rd_lim = 55; loc_lim = 72; del_lim = 92; clr_lim = 95;
      end
    endcase

    r = $urandom_range(99);
    if (r < ins_lim)      c = CMD_INSERT;
    else if (r < rd_lim)  c = CMD_READ;
    else if (r < loc_lim) c = CMD_LOCATE;
    else if (r < del_lim) c = CMD_DELETE;
    else if (r < clr_lim) c = CMD_CLEAR;
    else                  c = cmd_t'($urandom_range((1 << CMD_W) - 1, CMD_CLEAR + 1));

    // Most positions are legal for the current list, with a bias toward both
    // ends; the rest are zero, just past the end, or anything at all.
    r = $urandom_range(99);
    hi = (c == CMD_INSERT) ? sb.held + 1 : sb.held;
    if (r < 8) begin
      p = POS_W'($urandom_range((1 << POS_W) - 1));
    end else if (r < 14) begin
      p = POS_W'(hi + 1);
    end else if (r < 20 || hi == 0) begin
      p = '0;
    end else if (r < 30) begin
      p = ($urandom_range(1) == 0) ? POS_W'(1) : POS_W'(hi);
    end else begin
      p = POS_W'($urandom_range(hi, 1));
    end

    r = $urandom_range(99);
    if (c == CMD_LOCATE && sb.held > 0 && r < 60) begin
      v = sb.words[$urandom_range(sb.held - 1)];
    end else if (r < 75) begin
      v = VALUE_POOL[$urandom_range(7)];
    end else begin
      v = $urandom;
    end

    send_cmd(c, p, v);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor. A result is valid for exactly one cycle while done_o is
  // high, and it is taken at the rising edge that ends that cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_result_t got;
    if (rst_ni && done_o) begin
      got.rd_value  = result_value_o;
      got.found_pos = found_position_o;
      got.status    = status_o;
      got.count     = entry_count_o;
      sb.check_result(got);
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result is
  // transferred, and stops a hung run.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("** positional_array_list: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int idle_pcts [3];
    op_mix_e mix;
    int n;
    int ph;

    sb = new();
    sender_idle_pct = 0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    command_i  = CMD_CLEAR;
    position_i = '0;
    value_i    = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Read, delete, locate and insert on an empty list,
    // positions out of range for insert, read and delete, both extreme words,
    // a locate with a hit and one without, deletes in the middle and at the
    // end, the unused codes, and a clear of a list that holds something.
    send_cmd(CMD_READ,   6'd1, 32'h0);
    send_cmd(CMD_DELETE, 6'd1, 32'h0);
    send_cmd(CMD_LOCATE, 6'd0, 32'h0);
    send_cmd(CMD_INSERT, 6'd0, 32'h1234_5678);
    send_cmd(CMD_INSERT, 6'd2, 32'h1234_5678);
    send_cmd(CMD_INSERT, 6'd1, 32'h7fff_ffff);
    send_cmd(CMD_INSERT, 6'd1, 32'h8000_0000);
    send_cmd(CMD_INSERT, 6'd3, 32'h0000_0000);
    send_cmd(CMD_INSERT, 6'd2, 32'hffff_ffff);
    send_cmd(CMD_INSERT, 6'd6, 32'h0000_0001);
    send_cmd(CMD_READ,   6'd0, 32'h0);
    send_cmd(CMD_READ,   6'd5, 32'h0);
    send_cmd(CMD_READ,   6'd63, 32'h0);
    send_cmd(CMD_READ,   6'd4, 32'h0);
    send_cmd(CMD_LOCATE, 6'd0, 32'hffff_ffff);
    send_cmd(CMD_LOCATE, 6'd63, 32'h0000_3039);
    send_cmd(CMD_DELETE, 6'd2, 32'h0);
    send_cmd(CMD_DELETE, 6'd3, 32'h0);
    send_cmd(CMD_DELETE, 6'd0, 32'h0);
    send_cmd(cmd_t'(CMD_CLEAR + 1), 6'd1, 32'h0);
    send_cmd(cmd_t'(CMD_CLEAR + 2), 6'd2, 32'h5555_5555);
    send_cmd(cmd_t'((1 << CMD_W) - 1), 6'd63, 32'hffff_ffff);
    send_cmd(CMD_INSERT, 6'd1, 32'h0000_002a);
    send_cmd(CMD_CLEAR,  6'd63, 32'hffff_ffff);
    send_cmd(CMD_READ,   6'd1, 32'h0);

    // Random part in three phases: no sender gaps, gaps before nearly half
    // of the commands, and occasional gaps. The receiver cannot stall, so it
    // has no phases of its own. The command mix is picked anew every 40
    // commands so that the list runs full and runs dry again and again.
    idle_pcts = '{0, 46, 8};
    mix = MIX_FILL;
    for (ph = 0; ph < 3; ph++) begin
      sender_idle_pct = idle_pcts[ph];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % MIX_RUN == 0) begin
          mix = op_mix_e'($urandom_range(MIX_BALANCED, MIX_FILL));
        end
        send_random_cmd(mix);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;

    // Wait for every expected result, then a while longer to catch strays.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      sb.report_mismatch("results never delivered", VAL_W'(sb.pending_results.size()), '0);
    end

    if (sb.mismatches == 0) begin
      $display("** positional_array_list: PASSED **");
    end else begin
      $display("** positional_array_list: FAILED **");
    end
    $finish;
  end

endmodule

FILE: positional_array_list.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_ram.sv
hw/rtl/positional_array_list.sv
tb/tb_top.sv
